// File: rtl/smdm_pkg.sv
// Package for the serial MRAM device model: opcodes, frame phase type,
// array geometry and the per-word info passed down the result pipeline.
// No dependencies.
package smdm_pkg;

   localparam int ADDR_BITS = 15;
   localparam int MEM_DEPTH = 1 << ADDR_BITS;

   localparam logic [7:0] CMD_WREN  = 8'h06;
   localparam logic [7:0] CMD_WRDI  = 8'h04;
   localparam logic [7:0] CMD_RDSR  = 8'h05;
   localparam logic [7:0] CMD_WRSR  = 8'h01;
   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_WRITE = 8'h02;
   localparam logic [7:0] IDLE_BYTE = 8'hFF;

   typedef enum logic [1:0] {
      PH_CMD,
      PH_ADDR_HI,
      PH_ADDR_LO,
      PH_DATA
   } phase_type;

   // one result word on its way to the output register
   typedef struct packed {
      logic       use_mem;
      logic [7:0] miso;
      logic       ignored;
   } rsp_info_type;

endpackage

// File: rtl/smdm_ram.sv
// Byte array of the device: one port, synchronous write, registered read.
// Depends on smdm_pkg for the array geometry.
module smdm_ram (
   input  logic                           clock,
   input  logic                           rd_en,
   input  logic                           wr_en,
   input  logic [smdm_pkg::ADDR_BITS-1:0] addr,
   input  logic [7:0]                     wr_data,
   output logic [7:0]                     rd_data
);

   logic [7:0] mem [smdm_pkg::MEM_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      // read data holds until the next read, so a stalled word keeps it
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/smdm_ctrl.sv
// Frame decoder: command, address and data phases, write latch, status bits
// and the array access for each accepted word. Depends on smdm_pkg.
module smdm_ctrl (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic                           release_cs,
   input  logic [7:0]                     mosi,
   output logic                           push,
   output smdm_pkg::rsp_info_type         info,
   output logic                           mem_rd,
   output logic                           mem_wr,
   output logic [smdm_pkg::ADDR_BITS-1:0] mem_addr
);

   smdm_pkg::phase_type phase_ff, phase_in;
   logic [7:0] opcode_ff, opcode_in;
   logic [smdm_pkg::ADDR_BITS-1:0] addr_ff, addr_in;
   logic latch_ff, latch_in;
   logic [5:0] status_ff, status_in;
   logic [15:0] addr_wide;
   logic known;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= smdm_pkg::PH_CMD;
         opcode_ff <= '0;
         addr_ff   <= '0;
         latch_ff  <= 1'b0;
         status_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         addr_ff   <= addr_in;
         latch_ff  <= latch_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      opcode_in = opcode_ff;
      addr_in   = addr_ff;
      latch_in  = latch_ff;
      status_in = status_ff;
      addr_wide = '0;
      info.use_mem = 1'b0;
      info.miso    = smdm_pkg::IDLE_BYTE;
      mem_rd = 1'b0;
      mem_wr = 1'b0;
      if (release_cs) begin
         phase_in  = smdm_pkg::PH_CMD;
         opcode_in = '0;
      end else begin
         unique case (phase_ff)
            smdm_pkg::PH_CMD: begin
               opcode_in = mosi;
               if (mosi == smdm_pkg::CMD_WREN) begin
                  latch_in = 1'b1;
               end else if (mosi == smdm_pkg::CMD_WRDI) begin
                  latch_in = 1'b0;
               end
               phase_in = (mosi == smdm_pkg::CMD_READ || mosi == smdm_pkg::CMD_WRITE) ?
                          smdm_pkg::PH_ADDR_HI : smdm_pkg::PH_DATA;
            end
            smdm_pkg::PH_ADDR_HI: begin
               addr_wide = {mosi, 8'h00};
               addr_in   = addr_wide[smdm_pkg::ADDR_BITS-1:0];
               phase_in  = smdm_pkg::PH_ADDR_LO;
            end
            smdm_pkg::PH_ADDR_LO: begin
               addr_wide = 16'(addr_ff) | {8'h00, mosi};
               addr_in   = addr_wide[smdm_pkg::ADDR_BITS-1:0];
               phase_in  = smdm_pkg::PH_DATA;
            end
            smdm_pkg::PH_DATA: begin
               if (opcode_ff == smdm_pkg::CMD_RDSR) begin
                  info.miso = {status_ff, latch_ff, 1'b0};
               end else if (opcode_ff == smdm_pkg::CMD_WRSR) begin
                  if (latch_ff) begin
                     status_in = mosi[7:2];
                  end
               end else if (opcode_ff == smdm_pkg::CMD_READ) begin
                  info.use_mem = 1'b1;
                  mem_rd  = accept;
                  addr_in = addr_ff + 1'b1;
               end else if (opcode_ff == smdm_pkg::CMD_WRITE) begin
                  mem_wr  = accept & latch_ff;
                  addr_in = addr_ff + 1'b1;
               end
            end
            default: begin
               phase_in = smdm_pkg::PH_CMD;
            end
         endcase
      end
      known = (opcode_in == smdm_pkg::CMD_WREN) || (opcode_in == smdm_pkg::CMD_WRDI) ||
              (opcode_in == smdm_pkg::CMD_RDSR) || (opcode_in == smdm_pkg::CMD_WRSR) ||
              (opcode_in == smdm_pkg::CMD_READ) || (opcode_in == smdm_pkg::CMD_WRITE);
      info.ignored = !known ||
                     ((opcode_in == smdm_pkg::CMD_WRITE ||
                       opcode_in == smdm_pkg::CMD_WRSR) && !latch_in);
   end

   assign push     = accept & ~release_cs;
   assign mem_addr = addr_ff;

endmodule

// File: rtl/smdm_outq.sv
// Result pipeline: a stage that waits for the array read data, then the
// output register that drives the result stream. Depends on smdm_pkg.
module smdm_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  smdm_pkg::rsp_info_type info,
   input  logic [7:0]             mem_data,
   output logic                   ready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,
   output logic [0:0]             rsp_tuser
);

   logic s1_valid_ff, s1_valid_in;
   smdm_pkg::rsp_info_type s1_info_ff;
   logic out_valid_ff, out_valid_in;
   logic [7:0] out_miso_ff;
   logic out_ign_ff;
   logic adv;

   assign adv   = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign ready = ~s1_valid_ff | adv;

   assign s1_valid_in  = push | (s1_valid_ff & ~adv);
   assign out_valid_in = adv | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         s1_info_ff <= info;
      end
      if (adv) begin
         out_miso_ff <= s1_info_ff.use_mem ? mem_data : s1_info_ff.miso;
         out_ign_ff  <= s1_info_ff.ignored;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_miso_ff;
   assign rsp_tuser  = out_ign_ff;

endmodule

// File: rtl/spi_mram_device_model_top.sv
// Serial MRAM device model, top level: one SPI byte or chip-select release
// per input word, one result word per byte and none per release.
// A byte's result is registered in the read-wait stage, then in the output register.
// Throughput: one word per cycle while rsp_tready is high; the single array
// port serves the read or the write of each data byte in its accept cycle.
// Reset clears frame phase, opcode, address, write latch and status bits;
// the array is not cleared and holds undefined data until written.
module spi_mram_device_model_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] mosi
   input  logic [0:0] req_tuser,   // [0] action (1 = chip select release)
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] miso
   output logic [0:0] rsp_tuser    // [0] ignored
);

   logic accept;
   logic push;
   smdm_pkg::rsp_info_type info;
   logic mem_rd, mem_wr;
   logic [smdm_pkg::ADDR_BITS-1:0] mem_addr;
   logic [7:0] mem_data;

   assign accept = req_tvalid & req_tready;

   smdm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .release_cs (req_tuser[0]),
      .mosi       (req_tdata),
      .push       (push),
      .info       (info),
      .mem_rd     (mem_rd),
      .mem_wr     (mem_wr),
      .mem_addr   (mem_addr)
   );

   // reads and writes never share a frame, so no forwarding is needed
   smdm_ram u_ram (
      .clock   (clock),
      .rd_en   (mem_rd),
      .wr_en   (mem_wr),
      .addr    (mem_addr),
      .wr_data (req_tdata),
      .rd_data (mem_data)
   );

   smdm_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .info       (info),
      .mem_data   (mem_data),
      .ready      (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd && mem_wr))
      else $error("array read and write in the same cycle");

   a_mem_on_byte: assert property (@(posedge clock) disable iff (reset)
      (mem_rd || mem_wr) |-> (accept && !req_tuser[0]))
      else $error("array access without an accepted byte");

   a_stall_only_on_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled while the output side is free");

   a_push_to_output: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_tready && !rsp_tvalid) |=> ##1 rsp_tvalid)
      else $error("accepted byte did not reach the output");

endmodule

// File: tb/spi_mram_response_check.sv
`timescale 1ns / 1ps
// Response checker for the serial MRAM device model: follows every accepted
// request word, predicts the reply word and compares replies in order.
// Depends on smdm_pkg.
module spi_mram_response_check (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] mosi
   input  logic [0:0] req_tuser,   // [0] action (1 = chip select release)
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,   // [7:0] miso
   input  logic [0:0] rsp_tuser,   // [0] ignored
   output int         pending,
   output int         mismatches
);

   typedef struct packed {
      logic [7:0] miso;
      logic       ignored;
   } spi_reply_type;

   spi_reply_type                  due_replies [$];
   logic [7:0]                     mram [smdm_pkg::MEM_DEPTH];
   smdm_pkg::phase_type            frame_phase;
   logic [7:0]                     opcode_q;
   logic [smdm_pkg::ADDR_BITS-1:0] byte_addr;
   logic                           wel;
   logic [5:0]                     status_hi;
   int                             fail_count = 0;

   // one word from the host: a byte shifted in, or a chip select release
   task automatic shift_word(input logic cs_release, input logic [7:0] mosi);
      spi_reply_type r;
      logic [15:0] a16;
      logic known;
      r.miso = smdm_pkg::IDLE_BYTE;
      if (cs_release) begin
         frame_phase = smdm_pkg::PH_CMD;
         opcode_q = 8'h00;
      end else begin
         case (frame_phase)
            smdm_pkg::PH_CMD: begin
               opcode_q = mosi;
               if (mosi == smdm_pkg::CMD_WREN)
                  wel = 1'b1;
               else if (mosi == smdm_pkg::CMD_WRDI)
                  wel = 1'b0;
               frame_phase = (mosi == smdm_pkg::CMD_READ || mosi == smdm_pkg::CMD_WRITE) ?
                             smdm_pkg::PH_ADDR_HI : smdm_pkg::PH_DATA;
            end
            smdm_pkg::PH_ADDR_HI: begin
               a16 = {mosi, 8'h00};
               byte_addr = a16[smdm_pkg::ADDR_BITS-1:0];
               frame_phase = smdm_pkg::PH_ADDR_LO;
            end
            smdm_pkg::PH_ADDR_LO: begin
               a16 = {8'h00, mosi};
               byte_addr = byte_addr | a16[smdm_pkg::ADDR_BITS-1:0];
               frame_phase = smdm_pkg::PH_DATA;
            end
            default: begin
               case (opcode_q)
                  smdm_pkg::CMD_RDSR: r.miso = {status_hi, wel, 1'b0};
                  smdm_pkg::CMD_WRSR: begin
                     if (wel)
                        status_hi = mosi[7:2];
                  end
                  smdm_pkg::CMD_READ: begin
                     r.miso = mram[byte_addr];
                     byte_addr = byte_addr + 1'b1;
                  end
                  smdm_pkg::CMD_WRITE: begin
                     if (wel)
                        mram[byte_addr] = mosi;
                     byte_addr = byte_addr + 1'b1;
                  end
                  default: ;
               endcase
            end
         endcase
         known = opcode_q == smdm_pkg::CMD_WREN || opcode_q == smdm_pkg::CMD_WRDI ||
                 opcode_q == smdm_pkg::CMD_RDSR || opcode_q == smdm_pkg::CMD_WRSR ||
                 opcode_q == smdm_pkg::CMD_READ || opcode_q == smdm_pkg::CMD_WRITE;
         r.ignored = !known ||
                     ((opcode_q == smdm_pkg::CMD_WRITE || opcode_q == smdm_pkg::CMD_WRSR) &&
                      !wel);
         due_replies.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      spi_reply_type want;
      if (reset) begin
         due_replies.delete();
         frame_phase = smdm_pkg::PH_CMD;
         opcode_q = 8'h00;
         byte_addr = '0;
         wel = 1'b0;
         status_hi = '0;
      end else begin
         if (req_tvalid && req_tready)
            shift_word(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (due_replies.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: reply word with none due: miso %h ignored %b",
                           $time, rsp_tdata, rsp_tuser[0]);
               fail_count++;
            end else begin
               want = due_replies.pop_front();
               if (rsp_tdata !== want.miso || rsp_tuser[0] !== want.ignored) begin
                  if (fail_count < 10)
                     $display("%0t: expected miso %h ignored %b, got miso %h ignored %b",
                              $time, want.miso, want.ignored, rsp_tdata, rsp_tuser[0]);
                  fail_count++;
               end
            end
         end
      end
      pending <= due_replies.size();
      mismatches <= fail_count;
   end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the serial MRAM device model testbench: clock, reset, SPI frame
// stimulus and response back-pressure, verdict. Depends on smdm_pkg, the
// DUT and spi_mram_response_check.
module testbench;

   // opcodes the device does not know
   localparam logic [7:0] OP_JUNK_LO = 8'h00;
   localparam logic [7:0] OP_JUNK_HI = 8'hFF;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic [0:0] req_tuser = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   int         pending;
   int         mismatches;

   int send_idle_pct = 12;
   int recv_stall_pct = 63;
   int words_sent = 0;

   // what the stimulus knows it has stored, so reads stay on written bytes
   bit latch_shadow = 1'b0;
   bit written [smdm_pkg::MEM_DEPTH];
   int written_addrs [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   spi_mram_device_model_top dut (.*);

   spi_mram_response_check chk (.*);

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);

   initial begin
      #4_000_000;
      $display("[spi_mram_device_model_top] ERROR");
      $finish;
   end

   task automatic send_word(input logic cs_release, input logic [7:0] mosi);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser <= cs_release;
      req_tdata <= mosi;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      words_sent++;
   endtask

   // full frame: command, address for READ/WRITE, up to n data words, release
   task automatic run_frame(input logic [7:0] op, input int start, input int n);
      logic [15:0] a16;
      logic [smdm_pkg::ADDR_BITS-1:0] a;
      a = start[smdm_pkg::ADDR_BITS-1:0];
      send_word(1'b0, op);
      if (op == smdm_pkg::CMD_WREN)
         latch_shadow = 1'b1;
      else if (op == smdm_pkg::CMD_WRDI)
         latch_shadow = 1'b0;
      if (op == smdm_pkg::CMD_READ || op == smdm_pkg::CMD_WRITE) begin
         a16 = 16'($urandom);   // bits above the array width are dropped by the device
         a16[smdm_pkg::ADDR_BITS-1:0] = a;
         send_word(1'b0, a16[15:8]);
         send_word(1'b0, a16[7:0]);
      end
      for (int i = 0; i < n; i++) begin
         if (op == smdm_pkg::CMD_READ && !written[a])
            break;
         send_word(1'b0, 8'($urandom));
         if (op == smdm_pkg::CMD_WRITE && latch_shadow && !written[a]) begin
            written[a] = 1'b1;
            written_addrs.push_back(a);
         end
         if (op == smdm_pkg::CMD_READ || op == smdm_pkg::CMD_WRITE)
            a = a + 1'b1;
      end
      send_word(1'b1, 8'($urandom));
   endtask

   // READ or WRITE frame released inside its address bytes
   task automatic cut_frame(input logic [7:0] op, input int addr_bytes);
      send_word(1'b0, op);
      repeat (addr_bytes)
         send_word(1'b0, 8'($urandom));
      send_word(1'b1, 8'($urandom));
   endtask

   task automatic random_frame();
      int r;
      int start;
      int wstart;
      r = $urandom_range(99);
      start = (written_addrs.size() > 0) ?
              written_addrs[$urandom_range(written_addrs.size() - 1)] : 0;
      case ($urandom_range(9))
         0: wstart = smdm_pkg::MEM_DEPTH - $urandom_range(1, 6);
         1, 2, 3, 4: wstart = start;
         default: wstart = $urandom;
      endcase
      if (r < 22)
         run_frame(smdm_pkg::CMD_WRITE, wstart, $urandom_range(0, 8));
      else if (r < 47)
         run_frame(smdm_pkg::CMD_READ, start, $urandom_range(1, 8));
      else if (r < 57)
         run_frame(smdm_pkg::CMD_RDSR, 0, $urandom_range(0, 3));
      else if (r < 64)
         run_frame(smdm_pkg::CMD_WRSR, 0, $urandom_range(0, 3));
      else if (r < 77)
         run_frame(smdm_pkg::CMD_WREN, 0, $urandom_range(0, 1));
      else if (r < 82)
         run_frame(smdm_pkg::CMD_WRDI, 0, $urandom_range(0, 1));
      else if (r < 92)
         run_frame(8'($urandom), $urandom, $urandom_range(0, 3));
      else if (r < 97)
         cut_frame($urandom_range(1) ? smdm_pkg::CMD_READ : smdm_pkg::CMD_WRITE,
                   $urandom_range(0, 1));
      else
         send_word(1'b1, 8'($urandom));
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_word(1'b1, 8'($urandom));                     // release with no frame open
      run_frame(smdm_pkg::CMD_RDSR, 0, 1);               // status after reset
      run_frame(smdm_pkg::CMD_WRITE, 16, 1);             // latch clear: ignored, not stored
      run_frame(smdm_pkg::CMD_WRSR, 0, 1);               // latch clear: ignored
      run_frame(smdm_pkg::CMD_WREN, 0, 1);               // extra word after latch command
      run_frame(smdm_pkg::CMD_WRSR, 0, 2);               // last status word wins
      run_frame(smdm_pkg::CMD_RDSR, 0, 2);               // status repeats
      run_frame(smdm_pkg::CMD_WRITE, smdm_pkg::MEM_DEPTH - 1, 2);  // wraps to address zero
      run_frame(smdm_pkg::CMD_READ, smdm_pkg::MEM_DEPTH - 1, 2);
      cut_frame(smdm_pkg::CMD_WRITE, 1);
      cut_frame(smdm_pkg::CMD_READ, 0);
      run_frame(OP_JUNK_HI, 0, 1);
      run_frame(OP_JUNK_LO, 0, 1);
      run_frame(smdm_pkg::CMD_WRDI, 0, 1);
      run_frame(smdm_pkg::CMD_RDSR, 0, 1);

      while (words_sent < 250)
         random_frame();
      send_idle_pct = 63;
      recv_stall_pct = 12;
      while (words_sent < 500)
         random_frame();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (words_sent < 750)
         random_frame();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("[spi_mram_device_model_top] OK");
      else
         $display("[spi_mram_device_model_top] ERROR");
      $finish;
   end

endmodule

// File: sim.f
rtl/smdm_pkg.sv
rtl/smdm_ram.sv
rtl/smdm_ctrl.sv
rtl/smdm_outq.sv
rtl/spi_mram_device_model_top.sv
tb/spi_mram_response_check.sv
tb/testbench.sv
